>>> rtl/dtr_pkg.sv
// Shared types, register addresses and the divider tap helper for the timer block.
`default_nettype none

package dtr_pkg;

   // Item kinds carried on the input channel's tuser.
   typedef enum logic [1:0] {
      FuncTick  = 2'd0,
      FuncRead  = 2'd1,
      FuncWrite = 2'd2
   } func_type;

   // Bus addresses of the four timer registers.
   localparam logic [15:0] AddrDiv  = 16'hFF04;
   localparam logic [15:0] AddrTima = 16'hFF05;
   localparam logic [15:0] AddrTma  = 16'hFF06;
   localparam logic [15:0] AddrTac  = 16'hFF07;

   // Ticks in the overflow delay and in the reload window.
   localparam logic [2:0] WaitTicks = 3'd4;

   // Value returned for an unmapped address, and the fill for unused control bits.
   localparam logic [7:0] OpenBus  = 8'hFF;
   localparam logic [7:0] TacFill  = 8'hF8;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] address;
      logic [7:0]  write_data;
   } item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       timer_irq;
   } result_type;

   // Handshake status between the pipeline stages.
   typedef struct packed {
      logic valid;
      logic advance;
   } stage_ctl_type;

   // Level of the divider bit chosen by the control register, gated by its enable bit.
   function automatic logic tap_level(input logic [2:0] ctrl, input logic [15:0] div);
      logic level;
      case (ctrl[1:0])
         2'd0:    level = div[9];
         2'd1:    level = div[3];
         2'd2:    level = div[5];
         2'd3:    level = div[7];
         default: level = 1'b0;
      endcase
      return ctrl[2] & level;
   endfunction

endpackage

`default_nettype wire

>>> rtl/dtr_in_reg.sv
// Input register stage that holds one accepted item until the timer core takes it.
`default_nettype none

module dtr_in_reg (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire dtr_pkg::item_type      in_item,
   input  wire logic                   advance,
   output dtr_pkg::stage_ctl_type      ctl,
   output dtr_pkg::item_type           item
);

   logic              valid_ff;
   logic              valid_in;
   dtr_pkg::item_type item_ff;

   // The stage frees up in the same cycle in which the core consumes its item.
   assign in_ready = !valid_ff || advance;
   assign valid_in = (in_valid && in_ready) || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign ctl.valid   = valid_ff;
   assign ctl.advance = advance;
   assign item        = item_ff;

endmodule

`default_nettype wire

>>> rtl/dtr_core.sv
// Timer state registers and the single-pass next-state and read logic for one item.
`default_nettype none

module dtr_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire dtr_pkg::stage_ctl_type ctl,
   input  wire dtr_pkg::item_type      item,
   output dtr_pkg::result_type         result
);

   logic [15:0] div_ff,   div_in;
   logic [7:0]  tima_ff,  tima_in;
   logic [7:0]  tma_ff,   tma_in;
   logic [2:0]  tac_ff,   tac_in;
   logic [2:0]  wait_ff,  wait_in;
   logic [2:0]  guard_ff, guard_in;
   logic        step;
   logic        fire;

   assign fire = ctl.valid && ctl.advance;

   always_comb begin
      div_in           = div_ff;
      tima_in          = tima_ff;
      tma_in           = tma_ff;
      tac_in           = tac_ff;
      wait_in          = wait_ff;
      guard_in         = guard_ff;
      step             = 1'b0;
      result.read_data = 8'd0;
      result.timer_irq = 1'b0;

      if (fire) begin
         case (item.func)
            dtr_pkg::FuncTick: begin
               if (guard_ff != 3'd0) begin
                  guard_in = guard_ff - 3'd1;
               end
               // The delayed reload lands on the tick that empties the wait count.
               if (wait_ff != 3'd0) begin
                  wait_in = wait_ff - 3'd1;
                  if (wait_ff == 3'd1) begin
                     tima_in          = tma_ff;
                     result.timer_irq = 1'b1;
                     guard_in         = dtr_pkg::WaitTicks;
                  end
               end
               div_in = div_ff + 16'd1;
               step   = dtr_pkg::tap_level(tac_ff, div_ff) &&
                        !dtr_pkg::tap_level(tac_ff, div_in);
            end
            dtr_pkg::FuncRead: begin
               case (item.address)
                  dtr_pkg::AddrDiv:  result.read_data = div_ff[15:8];
                  dtr_pkg::AddrTima: result.read_data = tima_ff;
                  dtr_pkg::AddrTma:  result.read_data = tma_ff;
                  dtr_pkg::AddrTac:  result.read_data = dtr_pkg::TacFill | {5'd0, tac_ff};
                  default:           result.read_data = dtr_pkg::OpenBus;
               endcase
            end
            dtr_pkg::FuncWrite: begin
               case (item.address)
                  dtr_pkg::AddrDiv: begin
                     // A cleared divider reads low at every tap, so a high tap falls.
                     div_in = 16'd0;
                     step   = dtr_pkg::tap_level(tac_ff, div_ff);
                  end
                  dtr_pkg::AddrTima: begin
                     if (guard_ff == 3'd0) begin
                        tima_in = item.write_data;
                        wait_in = 3'd0;
                     end
                  end
                  dtr_pkg::AddrTma: begin
                     tma_in = item.write_data;
                     if (guard_ff != 3'd0) begin
                        tima_in = item.write_data;
                     end
                  end
                  dtr_pkg::AddrTac: begin
                     tac_in = item.write_data[2:0];
                     step   = dtr_pkg::tap_level(tac_ff, div_ff) &&
                              !dtr_pkg::tap_level(item.write_data[2:0], div_ff);
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase

         // A falling tap steps the counter unless a delay or reload window is running.
         if (step && wait_in == 3'd0 && guard_in == 3'd0) begin
            if (tima_in == 8'hFF) begin
               wait_in = dtr_pkg::WaitTicks;
            end
            tima_in = tima_in + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff   <= 16'd0;
         tima_ff  <= 8'd0;
         tma_ff   <= 8'd0;
         tac_ff   <= 3'd0;
         wait_ff  <= 3'd0;
         guard_ff <= 3'd0;
      end else begin
         div_ff   <= div_in;
         tima_ff  <= tima_in;
         tma_ff   <= tma_in;
         tac_ff   <= tac_in;
         wait_ff  <= wait_in;
         guard_ff <= guard_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/dtr_out_reg.sv
// Result register that holds one finished item until the downstream side takes it.
`default_nettype none

module dtr_out_reg (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire dtr_pkg::result_type result,
   input  wire logic                out_ready,
   output logic                     out_valid,
   output dtr_pkg::result_type      out_result,
   output logic                     space
);

   logic                valid_ff;
   logic                valid_in;
   dtr_pkg::result_type result_ff;

   assign space    = !valid_ff || out_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

`default_nettype wire

>>> rtl/divider_timer_with_reload_delay.sv
// Top level of the divider and timer block with delayed counter reload.
// An accepted item is held in the input register, and its result item is registered for rsp_.
// Throughput: one item per cycle, ticks and bus accesses alike, as long as rsp_tready stays high.
// The rate is set by the single pass of timer logic between the input and result registers.
// Reset is synchronous and active high; it clears the divider, counter, modulo, control,
// the overflow delay and the reload window, and empties both pipeline registers.
`default_nettype none

module divider_timer_with_reload_delay (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input items.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [15:0] address, [23:16] write_data
   input  wire logic [1:0]  req_tuser,   // [1:0] func: tick, bus read or bus write
   // Result items.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // [7:0] read_data, [8] timer_irq, [15:9] zero
);

   dtr_pkg::item_type      in_item;
   dtr_pkg::item_type      stage_item;
   dtr_pkg::stage_ctl_type stage_ctl;
   dtr_pkg::result_type    core_result;
   dtr_pkg::result_type    out_result;
   logic                   out_space;
   logic                   advance;

   assign in_item.func       = req_tuser;
   assign in_item.address    = req_tdata[15:0];
   assign in_item.write_data = req_tdata[23:16];

   // The item in the input register is processed whenever the result register
   // is empty or is being emptied in this cycle, so items flow back to back.
   // While a result item is stalled, one more item can still be taken into an
   // empty input register; once both registers are full, req_tready drops.
   assign advance = stage_ctl.valid && out_space;

   dtr_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_item  (in_item),
      .advance  (advance),
      .ctl      (stage_ctl),
      .item     (stage_item)
   );

   // All timer state lives here and is updated by the item being processed.
   dtr_core u_core (
      .clock  (clock),
      .reset  (reset),
      .ctl    (stage_ctl),
      .item   (stage_item),
      .result (core_result)
   );

   dtr_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (core_result),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_result (out_result),
      .space      (out_space)
   );

   assign rsp_tdata = {7'd0, out_result.timer_irq, out_result.read_data};

endmodule

`default_nettype wire

>>> rtl/dtr_checker.sv
// Port-level checker for the timer block and its bind to the top level.
`default_nettype none

module dtr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [23:0] req_tdata,
   input wire logic [1:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);

   // A stalled result item holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result item changed");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // An interrupt comes only from a tick, which never returns read data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> rsp_tdata[7:0] == 8'd0)
      else $error("interrupt result carries read data");

   // Nothing reaches the result side without an item having been accepted before.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2) || $past(rsp_tvalid, 1) ||
                            $past(req_tvalid && req_tready, 3))
      else $error("result item without an accepted item");

endmodule

bind divider_timer_with_reload_delay dtr_checker u_dtr_checker (.*);

`default_nettype wire

>>> tb/timer_check_pkg.sv
// Scoreboard class that predicts the timer block's result items and checks them.
`timescale 1ns / 100ps

package timer_check_pkg;
   import dtr_pkg::*;

   // Item kind that the block must accept and answer with zeros.
   localparam logic [1:0] FuncUnused = 2'd3;

   // Divider bit watched for each value of the control select field.
   localparam int unsigned TapPos[4] = '{9, 3, 5, 7};

   // Only the first few mismatches are printed in full.
   localparam int unsigned MaxReports = 10;

   class timer_scoreboard;
      logic [15:0] div_count;
      logic [7:0]  tima;
      logic [7:0]  tma;
      logic [2:0]  tac;
      logic [2:0]  ovf_wait;
      logic [2:0]  guard;
      result_type  due_results[$];
      int unsigned mismatches;

      function new();
         div_count  = '0;
         tima       = '0;
         tma        = '0;
         tac        = '0;
         ovf_wait   = '0;
         guard      = '0;
         mismatches = 0;
      endfunction

      function logic tap_high();
         return tac[2] && div_count[TapPos[tac[1:0]]];
      endfunction

      // Steps the counter when the watched bit went from high to low,
      // unless an overflow delay or a reload window is running.
      function void step_on_fall(logic was_high);
         if (!was_high || tap_high())
            return;
         if (ovf_wait != 0 || guard != 0)
            return;
         tima = tima + 8'd1;
         if (tima == 8'd0)
            ovf_wait = WaitTicks;
      endfunction

      function void predict_item(logic [1:0] func, logic [15:0] addr, logic [7:0] data);
         result_type r;
         logic       was_high;
         r = '0;
         case (func)
            FuncTick: begin
               if (guard != 0)
                  guard--;
               if (ovf_wait != 0) begin
                  ovf_wait--;
                  if (ovf_wait == 0) begin
                     tima        = tma;
                     r.timer_irq = 1'b1;
                     guard       = WaitTicks;
                  end
               end
               was_high = tap_high();
               div_count++;
               step_on_fall(was_high);
            end
            FuncRead: begin
               case (addr)
                  AddrDiv:  r.read_data = div_count[15:8];
                  AddrTima: r.read_data = tima;
                  AddrTma:  r.read_data = tma;
                  AddrTac:  r.read_data = TacFill | {5'd0, tac};
                  default:  r.read_data = OpenBus;
               endcase
            end
            FuncWrite: begin
               was_high = tap_high();
               case (addr)
                  AddrDiv: begin
                     div_count = '0;
                     step_on_fall(was_high);
                  end
                  AddrTima: begin
                     if (guard == 0) begin
                        tima     = data;
                        ovf_wait = '0;
                     end
                  end
                  AddrTma: begin
                     tma = data;
                     if (guard != 0)
                        tima = data;
                  end
                  AddrTac: begin
                     tac = data[2:0];
                     step_on_fall(was_high);
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
         due_results.push_back(r);
      endfunction

      function void check_result(logic [15:0] tdata);
         result_type want;
         if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MaxReports)
               $display("result item %04h arrived with nothing due", tdata);
            return;
         end
         want = due_results.pop_front();
         if (tdata[7:0] !== want.read_data || tdata[8] !== want.timer_irq) begin
            mismatches++;
            if (mismatches <= MaxReports)
               $display("mismatch: read_data exp %02h got %02h, timer_irq exp %0b got %0b",
                        want.read_data, tdata[7:0], want.timer_irq, tdata[8]);
         end
      endfunction

      function int unsigned results_due();
         return due_results.size();
      endfunction
   endclass

endpackage

>>> tb/tb_divider_timer_with_reload_delay.sv
// Self-checking testbench for the divider and timer block with delayed counter reload.
`timescale 1ns / 100ps

module tb_divider_timer_with_reload_delay;
   import dtr_pkg::*;
   import timer_check_pkg::*;

   // Items per random phase; with the overshoot of the last sequence in each
   // phase and the directed items, the run sends roughly 550 items.
   localparam int unsigned PhaseItems   = 105;
   // Length of the receiver's long hold-off, in cycles.
   localparam int unsigned LongHold     = 300;
   // Cycles allowed for the whole run before it is declared hung.
   localparam int unsigned CycleLimit   = 200000;
   // Cycles waited after the last result so that stray items would show up.
   localparam int unsigned SettleCycles = 10;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;    // [15:0] address, [23:16] write_data
   logic [1:0]  req_tuser;    // [1:0] func
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;    // [7:0] read_data, [8] timer_irq, [15:9] zero

   // Chance in percent that the sender idles or the receiver stalls in a cycle.
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned items_sent     = 0;
   int unsigned cycle_count    = 0;
   // The stimulus bumps hold_req to ask for a long hold-off; the receiver counts it out.
   int unsigned hold_req       = 0;
   int unsigned hold_seen      = 0;
   int unsigned hold_left      = 0;

   timer_scoreboard board = new();

   divider_timer_with_reload_delay i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Both channels are sampled at the rising edge, where every input driven at the
   // falling edge is stable. An accepted item feeds the predictor; an accepted
   // result item is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         board.predict_item(req_tuser, req_tdata[15:0], req_tdata[23:16]);
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata);
   end

   // Receiver: stalls at random at the current rate, or holds off entirely for a
   // long stretch when the stimulus asks for it.
   initial begin : receiver
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = LongHold;
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Ends a hung run.
   initial begin : watchdog
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [15:0] any_timer_addr();
      case ($urandom_range(3))
         0:       return AddrDiv;
         1:       return AddrTima;
         2:       return AddrTma;
         default: return AddrTac;
      endcase
   endfunction

   // Offers one item, starting at a falling edge, after a random idle gap, and
   // returns at the falling edge after the item was taken. The valid line gets
   // at most one assignment per falling edge.
   task automatic send_item(input logic [1:0] func, input logic [15:0] addr,
                            input logic [7:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {data, addr};
      do begin
         @(posedge clock);
      end while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   // Stops offering items until every predicted result item has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (board.results_due() != 0)
         @(negedge clock);
   endtask

   initial begin : stimulus
      int unsigned phase_start;
      int unsigned burst;
      int unsigned roll;
      logic [15:0] addr;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = FuncTick;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. Registers read back their reset values, the control
      // register reads with its upper bits set, and unmapped reads give 0xFF.
      send_item(FuncRead, AddrDiv, 8'h00);
      send_item(FuncRead, AddrTima, 8'h00);
      send_item(FuncRead, AddrTma, 8'h00);
      send_item(FuncRead, AddrTac, 8'h00);
      send_item(FuncRead, 16'h0000, 8'hFF);
      // The unused item kind does nothing; an unmapped write is ignored.
      send_item(FuncUnused, AddrTima, 8'hFF);
      send_item(FuncWrite, 16'hFFFF, 8'hFF);
      // Control keeps only its low bits: enabled, watching divider bit 3.
      send_item(FuncWrite, AddrTac, 8'hFD);
      send_item(FuncWrite, AddrTima, 8'hFF);
      send_item(FuncWrite, AddrTma, 8'h80);
      // Eight ticks raise divider bit 3; clearing the divider then makes a
      // falling edge, the counter wraps and the overflow delay starts.
      repeat (8) send_item(FuncTick, 16'h0000, 8'h00);
      send_item(FuncWrite, AddrDiv, 8'h5A);
      // The fourth tick completes the reload and raises the interrupt.
      repeat (4) send_item(FuncTick, 16'hFFFF, 8'hFF);
      // In the reload window a counter write is ignored and a modulo write
      // also lands in the counter.
      send_item(FuncWrite, AddrTima, 8'h00);
      send_item(FuncWrite, AddrTma, 8'h00);
      send_item(FuncRead, AddrTima, 8'h00);
      drain_results();

      // Random part, in four phases with different idling on each side.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 85;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 85;
            end
            default: begin
               send_idle_pct  = 33;
               recv_stall_pct = 33;
            end
         endcase
         // In the first phase the receiver holds off while items keep coming,
         // so the pipeline fills and the input stalls.
         if (phase == 0)
            hold_req++;
         phase_start = items_sent;
         while (items_sent - phase_start < PhaseItems) begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4, 5: begin
                  // Overflow run: counter set near the top with a fast tap, then
                  // mostly ticks, mixed with reads and writes that can land in
                  // the overflow delay or the reload window.
                  send_item(FuncWrite, AddrTma, 8'($urandom));
                  send_item(FuncWrite, AddrTac,
                            {5'($urandom), 1'b1, 2'($urandom_range(1, 3))});
                  send_item(FuncWrite, AddrTima, 8'hFC | 8'($urandom_range(3)));
                  burst = $urandom_range(30, 70);
                  repeat (burst) begin
                     roll = $urandom_range(99);
                     if (roll < 70)
                        send_item(FuncTick, 16'($urandom), 8'($urandom));
                     else if (roll < 85)
                        send_item(FuncRead, any_timer_addr(), 8'($urandom));
                     else if (roll < 95)
                        send_item(FuncWrite, (roll < 90) ? AddrTima : AddrTma, 8'($urandom));
                     else
                        send_item(FuncWrite, (roll < 98) ? AddrDiv : AddrTac, 8'($urandom));
                  end
               end
               6, 7: begin
                  // Noise: any item kind, addresses near and far from the timer.
                  repeat (10) begin
                     case ($urandom_range(3))
                        0:       addr = any_timer_addr();
                        1:       addr = 16'hFF00 | 16'($urandom_range(15));
                        default: addr = 16'($urandom);
                     endcase
                     send_item(2'($urandom_range(3)), addr, 8'($urandom));
                  end
               end
               default: begin
                  // Plain counting with occasional register reads.
                  repeat (20) begin
                     if ($urandom_range(3) == 0)
                        send_item(FuncRead, any_timer_addr(), 8'h00);
                     else
                        send_item(FuncTick, 16'h0000, 8'h00);
                  end
               end
            endcase
         end
         drain_results();
      end

      repeat (SettleCycles) @(posedge clock);
      if (board.mismatches == 0 && board.results_due() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
